// ----- design/i2c_master_byte_engine_assert.svh -----
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define I2C_MBE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2C_MBE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/i2c_mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, sequencer operation codes, the operation program and types.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_mbe_pkg;

    localparam int CMD_W   = 3;
    localparam int PHASE_W = 5;
    localparam int OP_W    = 4;
    localparam int HB_W    = 16;

    localparam logic [HB_W-1:0] HALFBIT_RESET = 16'd125;

    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [OP_W-1:0] OP_END         = 4'd0;
    localparam logic [OP_W-1:0] OP_SCL0        = 4'd1;
    localparam logic [OP_W-1:0] OP_SCL1        = 4'd2;
    localparam logic [OP_W-1:0] OP_SDA0        = 4'd3;
    localparam logic [OP_W-1:0] OP_SDA1        = 4'd4;
    localparam logic [OP_W-1:0] OP_SDA_TXBIT   = 4'd5;
    localparam logic [OP_W-1:0] OP_SDA_ACKOUT  = 4'd6;
    localparam logic [OP_W-1:0] OP_SCL0_TXNEXT = 4'd7;
    localparam logic [OP_W-1:0] OP_SCL0_ACKIN  = 4'd8;
    localparam logic [OP_W-1:0] OP_SCL0_RXBIT  = 4'd9;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
    localparam logic [PHASE_W-1:0] PH_START     = 5'd1;
    localparam logic [PHASE_W-1:0] PH_STOP      = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WRITE     = 5'd11;
    localparam logic [PHASE_W-1:0] PH_WRITE_ACK = 5'd14;
    localparam logic [PHASE_W-1:0] PH_READ      = 5'd18;
    localparam logic [PHASE_W-1:0] PH_READ_ACK  = 5'd21;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [7:0]       tx_byte;
        logic             nack_to_send;
        logic             scl_in;
        logic             sda_in;
    } t_request;

    function automatic logic [OP_W-1:0] program_op(input logic [PHASE_W-1:0] ph);
        logic [OP_W-1:0] op;
        case (ph)
            5'd1:    op = OP_SCL0;
            5'd2:    op = OP_SDA1;
            5'd3:    op = OP_SCL1;
            5'd4:    op = OP_SDA0;
            5'd5:    op = OP_SCL0;
            5'd7:    op = OP_SDA0;
            5'd8:    op = OP_SCL1;
            5'd9:    op = OP_SDA1;
            5'd11:   op = OP_SDA_TXBIT;
            5'd12:   op = OP_SCL1;
            5'd13:   op = OP_SCL0_TXNEXT;
            5'd14:   op = OP_SDA1;
            5'd15:   op = OP_SCL1;
            5'd16:   op = OP_SCL0_ACKIN;
            5'd18:   op = OP_SDA1;
            5'd19:   op = OP_SCL1;
            5'd20:   op = OP_SCL0_RXBIT;
            5'd21:   op = OP_SDA_ACKOUT;
            5'd22:   op = OP_SCL1;
            5'd23:   op = OP_SCL0;
            default: op = OP_END;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ----- design/i2c_mbe_core.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer core
// Holds the bus sequencer state and advances it by one tick per request.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbe_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_step,
    input  i2c_mbe_pkg::t_request              i_req,
    input  wire  [i2c_mbe_pkg::HB_W-1:0]       i_halfbit,
    output i2c_mbe_pkg::t_result               o_res
);

    logic [i2c_mbe_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [3:0]                      r_bit_count, n_bit_count;
    logic [7:0]                      r_shift, n_shift;
    logic [i2c_mbe_pkg::HB_W-1:0]    r_wait, n_wait;
    logic                            r_scl, n_scl;
    logic                            r_sda, n_sda;
    logic                            r_ack_flag, n_ack_flag;
    logic                            r_ack_out, n_ack_out;
    logic                            r_stretch, n_stretch;
    logic [7:0]                      r_rx_last, n_rx_last;

    always_comb begin
        logic                            do_apply;
        logic                            done;
        logic [i2c_mbe_pkg::OP_W-1:0]    op;
        logic [i2c_mbe_pkg::PHASE_W-1:0] nxt;

        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack_flag  = r_ack_flag;
        n_ack_out   = r_ack_out;
        n_stretch   = r_stretch;
        n_rx_last   = r_rx_last;
        do_apply    = 1'b0;
        done        = 1'b0;

        if (r_phase == i2c_mbe_pkg::PH_IDLE) begin
            if (i_req.command inside {[i2c_mbe_pkg::CMD_START:i2c_mbe_pkg::CMD_READ]}) begin
                n_bit_count = 4'd0;
                do_apply    = 1'b1;
                case (i_req.command)
                    i2c_mbe_pkg::CMD_START: begin
                        n_phase = i2c_mbe_pkg::PH_START;
                    end
                    i2c_mbe_pkg::CMD_STOP: begin
                        n_phase = i2c_mbe_pkg::PH_STOP;
                    end
                    i2c_mbe_pkg::CMD_WRITE: begin
                        n_phase = i2c_mbe_pkg::PH_WRITE;
                        n_shift = i_req.tx_byte;
                    end
                    default: begin
                        n_phase   = i2c_mbe_pkg::PH_READ;
                        n_shift   = 8'd0;
                        n_ack_out = i_req.nack_to_send;
                    end
                endcase
            end
        end else if (!(r_stretch && !i_req.scl_in)) begin
            n_stretch = 1'b0;
            if (r_wait != '0) begin
                n_wait = r_wait - 1'b1;
            end else begin
                do_apply = 1'b1;
            end
        end

        op  = i2c_mbe_pkg::program_op(n_phase);
        nxt = n_phase + 1'b1;
        if (do_apply) begin
            case (op)
                i2c_mbe_pkg::OP_SCL0:       n_scl = 1'b0;
                i2c_mbe_pkg::OP_SCL1:       n_scl = 1'b1;
                i2c_mbe_pkg::OP_SDA0:       n_sda = 1'b0;
                i2c_mbe_pkg::OP_SDA1:       n_sda = 1'b1;
                i2c_mbe_pkg::OP_SDA_TXBIT:  n_sda = n_shift[7];
                i2c_mbe_pkg::OP_SDA_ACKOUT: n_sda = n_ack_out;
                i2c_mbe_pkg::OP_SCL0_TXNEXT: begin
                    n_scl       = 1'b0;
                    n_shift     = {n_shift[6:0], 1'b0};
                    n_bit_count = n_bit_count + 1'b1;
                    nxt = (n_bit_count >= 4'd8) ? i2c_mbe_pkg::PH_WRITE_ACK
                                                : i2c_mbe_pkg::PH_WRITE;
                end
                i2c_mbe_pkg::OP_SCL0_ACKIN: begin
                    n_scl      = 1'b0;
                    n_ack_flag = !i_req.sda_in;
                end
                i2c_mbe_pkg::OP_SCL0_RXBIT: begin
                    n_scl       = 1'b0;
                    n_shift     = {n_shift[6:0], i_req.sda_in};
                    n_bit_count = n_bit_count + 1'b1;
                    if (n_bit_count >= 4'd8) begin
                        n_rx_last = n_shift;
                        nxt       = i2c_mbe_pkg::PH_READ_ACK;
                    end else begin
                        nxt = i2c_mbe_pkg::PH_READ;
                    end
                end
                default: begin
                end
            endcase
            if (op == i2c_mbe_pkg::OP_END) begin
                n_phase   = i2c_mbe_pkg::PH_IDLE;
                n_stretch = 1'b0;
                n_wait    = '0;
                done      = 1'b1;
            end else begin
                n_phase   = nxt;
                n_wait    = i_halfbit;
                n_stretch = (op == i2c_mbe_pkg::OP_SCL1);
            end
        end

        o_res.scl_release = n_scl;
        o_res.sda_release = n_sda;
        o_res.busy        = (n_phase != i2c_mbe_pkg::PH_IDLE);
        o_res.done        = done;
        o_res.rx_byte     = n_rx_last;
        o_res.ack_seen    = n_ack_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2c_mbe_pkg::PH_IDLE;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_wait      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack_flag  <= 1'b0;
            r_ack_out   <= 1'b0;
            r_stretch   <= 1'b0;
            r_rx_last   <= 8'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack_flag  <= n_ack_flag;
            r_ack_out   <= n_ack_out;
            r_stretch   <= n_stretch;
            r_rx_last   <= n_rx_last;
        end
    end

endmodule

`default_nettype wire

// ----- design/i2c_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine, one request per bus tick
// Requests pass the input register, the sequencer step and the result register;
// one request per cycle while the result side does not stall.
// Reset (synchronous, active low) leaves the bus released, idle, 125 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2c_master_byte_engine (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [i2c_mbe_pkg::CMD_W-1:0]  i_command,
    input  wire  [7:0]                     i_tx_byte,
    input  wire                            i_nack_to_send,
    input  wire                            i_scl_in,
    input  wire                            i_sda_in,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_scl_release,
    output logic                           o_sda_release,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic [7:0]                     o_rx_byte,
    output logic                           o_ack_seen,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [i2c_mbe_pkg::HB_W-1:0]   i_cfg_data
);

    logic                              r_in_vld, n_in_vld;
    i2c_mbe_pkg::t_request             r_in;
    logic                              r_out_vld, n_out_vld;
    i2c_mbe_pkg::t_result              r_out;
    logic [i2c_mbe_pkg::HB_W-1:0]      r_halfbit;
    logic                              adv;
    logic                              in_take;
    i2c_mbe_pkg::t_result              core_res;

    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !adv;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign n_in_vld  = in_take ? 1'b1 : (adv ? 1'b0 : r_in_vld);
    assign n_out_vld = adv ? 1'b1 : (i_out_stall ? r_out_vld : 1'b0);

    i2c_mbe_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (adv),
        .i_req     (r_in),
        .i_halfbit (r_halfbit),
        .o_res     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_halfbit <= i2c_mbe_pkg::HALFBIT_RESET;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_halfbit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.command      <= i_command;
            r_in.tx_byte      <= i_tx_byte;
            r_in.nack_to_send <= i_nack_to_send;
            r_in.scl_in       <= i_scl_in;
            r_in.sda_in       <= i_sda_in;
        end
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_scl_release = r_out.scl_release;
    assign o_sda_release = r_out.sda_release;
    assign o_busy_res    = r_out.busy;
    assign o_done_res    = r_out.done;
    assign o_rx_byte     = r_out.rx_byte;
    assign o_ack_seen    = r_out.ack_seen;

    `I2C_MBE_ASSERT_NOW(a_done_not_busy, r_out_vld && r_out.done, !r_out.busy, "done while busy")
    `I2C_MBE_ASSERT_NOW(a_stall_needs_full, o_in_stall, r_in_vld, "stall with empty input stage")
    `I2C_MBE_ASSERT_NEXT(a_held_request, r_in_vld && !adv, r_in_vld, "held request was lost")
    `I2C_MBE_ASSERT_NEXT(a_result_lands, adv, r_out_vld, "stepped request left no result")

endmodule

`default_nettype wire

// ----- tb/sv/i2c_master_byte_engine_checker.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine result checker
// Watches the request, result and configuration channels of the byte engine.
// Every accepted request advances a private copy of the pin sequencer, and the
// expected pin levels and status go into a queue. Every accepted result is
// compared field by field with the oldest entry of that queue.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [i2c_mbe_pkg::CMD_W-1:0]    i_command,
    input  logic [7:0]                       i_tx_byte,
    input  logic                             i_nack_to_send,
    input  logic                             i_scl_in,
    input  logic                             i_sda_in,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_scl_release,
    input  logic                             i_sda_release,
    input  logic                             i_busy_res,
    input  logic                             i_done_res,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_ack_seen,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [i2c_mbe_pkg::HB_W-1:0]     i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output logic                             o_seq_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [i2c_mbe_pkg::HB_W-1:0]    hb_ticks;
    logic [i2c_mbe_pkg::PHASE_W-1:0] seq_phase;
    logic [3:0]                      bits_done;
    logic [7:0]                      shifter;
    logic [i2c_mbe_pkg::HB_W-1:0]    wait_left;
    logic                            scl_drv;
    logic                            sda_drv;
    logic                            slave_acked;
    logic                            read_nack;
    logic                            stretch_wait;
    logic [7:0]                      last_rx;
    i2c_mbe_pkg::t_result            pin_levels_q[$];
    int                              fails;

    function automatic logic [i2c_mbe_pkg::OP_W-1:0] op_at(
        input logic [i2c_mbe_pkg::PHASE_W-1:0] p);
        logic [i2c_mbe_pkg::OP_W-1:0] op;
        case (p)
            i2c_mbe_pkg::PH_START,
            i2c_mbe_pkg::PH_START + 5'd4,
            i2c_mbe_pkg::PH_READ_ACK + 5'd2: op = i2c_mbe_pkg::OP_SCL0;
            i2c_mbe_pkg::PH_START + 5'd1,
            i2c_mbe_pkg::PH_STOP + 5'd2,
            i2c_mbe_pkg::PH_WRITE_ACK,
            i2c_mbe_pkg::PH_READ: op = i2c_mbe_pkg::OP_SDA1;
            i2c_mbe_pkg::PH_START + 5'd2,
            i2c_mbe_pkg::PH_STOP + 5'd1,
            i2c_mbe_pkg::PH_WRITE + 5'd1,
            i2c_mbe_pkg::PH_WRITE_ACK + 5'd1,
            i2c_mbe_pkg::PH_READ + 5'd1,
            i2c_mbe_pkg::PH_READ_ACK + 5'd1: op = i2c_mbe_pkg::OP_SCL1;
            i2c_mbe_pkg::PH_START + 5'd3,
            i2c_mbe_pkg::PH_STOP: op = i2c_mbe_pkg::OP_SDA0;
            i2c_mbe_pkg::PH_WRITE: op = i2c_mbe_pkg::OP_SDA_TXBIT;
            i2c_mbe_pkg::PH_WRITE + 5'd2: op = i2c_mbe_pkg::OP_SCL0_TXNEXT;
            i2c_mbe_pkg::PH_WRITE_ACK + 5'd2: op = i2c_mbe_pkg::OP_SCL0_ACKIN;
            i2c_mbe_pkg::PH_READ + 5'd2: op = i2c_mbe_pkg::OP_SCL0_RXBIT;
            i2c_mbe_pkg::PH_READ_ACK: op = i2c_mbe_pkg::OP_SDA_ACKOUT;
            default: op = i2c_mbe_pkg::OP_END;
        endcase
        return op;
    endfunction

    task automatic do_pin_op(input logic sda_pin, output logic finished);
        logic [i2c_mbe_pkg::OP_W-1:0]    op;
        logic [i2c_mbe_pkg::PHASE_W-1:0] nxt;
        op = op_at(seq_phase);
        nxt = seq_phase + 5'd1;
        finished = 1'b0;
        case (op)
            i2c_mbe_pkg::OP_SCL0: scl_drv = 1'b0;
            i2c_mbe_pkg::OP_SCL1: scl_drv = 1'b1;
            i2c_mbe_pkg::OP_SDA0: sda_drv = 1'b0;
            i2c_mbe_pkg::OP_SDA1: sda_drv = 1'b1;
            i2c_mbe_pkg::OP_SDA_TXBIT: sda_drv = shifter[7];
            i2c_mbe_pkg::OP_SDA_ACKOUT: sda_drv = read_nack;
            i2c_mbe_pkg::OP_SCL0_TXNEXT: begin
                scl_drv = 1'b0;
                shifter = shifter << 1;
                bits_done = bits_done + 4'd1;
                nxt = (bits_done >= 4'd8) ? i2c_mbe_pkg::PH_WRITE_ACK
                                          : i2c_mbe_pkg::PH_WRITE;
            end
            i2c_mbe_pkg::OP_SCL0_ACKIN: begin
                scl_drv = 1'b0;
                slave_acked = !sda_pin;
            end
            i2c_mbe_pkg::OP_SCL0_RXBIT: begin
                scl_drv = 1'b0;
                shifter = {shifter[6:0], sda_pin};
                bits_done = bits_done + 4'd1;
                if (bits_done >= 4'd8) begin
                    last_rx = shifter;
                    nxt = i2c_mbe_pkg::PH_READ_ACK;
                end else begin
                    nxt = i2c_mbe_pkg::PH_READ;
                end
            end
            default: finished = 1'b1;
        endcase
        if (finished) begin
            seq_phase = i2c_mbe_pkg::PH_IDLE;
            stretch_wait = 1'b0;
            wait_left = '0;
        end else begin
            seq_phase = nxt;
            wait_left = hb_ticks;
            stretch_wait = (op == i2c_mbe_pkg::OP_SCL1);
        end
    endtask

    task automatic advance_bus(input i2c_mbe_pkg::t_request rq,
                               output i2c_mbe_pkg::t_result res);
        logic finished;
        logic go;
        finished = 1'b0;
        go = 1'b0;
        if (seq_phase == i2c_mbe_pkg::PH_IDLE) begin
            case (rq.command)
                i2c_mbe_pkg::CMD_START: begin
                    seq_phase = i2c_mbe_pkg::PH_START;
                    go = 1'b1;
                end
                i2c_mbe_pkg::CMD_STOP: begin
                    seq_phase = i2c_mbe_pkg::PH_STOP;
                    go = 1'b1;
                end
                i2c_mbe_pkg::CMD_WRITE: begin
                    seq_phase = i2c_mbe_pkg::PH_WRITE;
                    shifter = rq.tx_byte;
                    go = 1'b1;
                end
                i2c_mbe_pkg::CMD_READ: begin
                    seq_phase = i2c_mbe_pkg::PH_READ;
                    shifter = '0;
                    read_nack = rq.nack_to_send;
                    go = 1'b1;
                end
                default: go = 1'b0;
            endcase
            if (go) begin
                bits_done = '0;
                do_pin_op(rq.sda_in, finished);
            end
        end else if (!(stretch_wait && !rq.scl_in)) begin
            stretch_wait = 1'b0;
            if (wait_left != '0) begin
                wait_left = wait_left - 1'b1;
            end else begin
                do_pin_op(rq.sda_in, finished);
            end
        end
        res.scl_release = scl_drv;
        res.sda_release = sda_drv;
        res.busy = (seq_phase != i2c_mbe_pkg::PH_IDLE);
        res.done = finished;
        res.rx_byte = last_rx;
        res.ack_seen = slave_acked;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        i2c_mbe_pkg::t_request rq;
        i2c_mbe_pkg::t_result  want;
        if (!i_rst_n) begin
            hb_ticks = i2c_mbe_pkg::HALFBIT_RESET;
            seq_phase = i2c_mbe_pkg::PH_IDLE;
            bits_done = '0;
            shifter = '0;
            wait_left = '0;
            scl_drv = 1'b1;
            sda_drv = 1'b1;
            slave_acked = 1'b0;
            read_nack = 1'b0;
            stretch_wait = 1'b0;
            last_rx = '0;
            pin_levels_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                hb_ticks = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (pin_levels_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0h", $time,
                             {i_scl_release, i_sda_release, i_busy_res, i_done_res,
                              i_rx_byte, i_ack_seen});
                    fails++;
                end else begin
                    want = pin_levels_q.pop_front();
                    check_field("scl_release", 8'(want.scl_release), 8'(i_scl_release));
                    check_field("sda_release", 8'(want.sda_release), 8'(i_sda_release));
                    check_field("busy_res", 8'(want.busy), 8'(i_busy_res));
                    check_field("done_res", 8'(want.done), 8'(i_done_res));
                    check_field("rx_byte", want.rx_byte, i_rx_byte);
                    check_field("ack_seen", 8'(want.ack_seen), 8'(i_ack_seen));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rq.command = i_command;
                rq.tx_byte = i_tx_byte;
                rq.nack_to_send = i_nack_to_send;
                rq.scl_in = i_scl_in;
                rq.sda_in = i_sda_in;
                advance_bus(rq, want);
                pin_levels_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending <= pin_levels_q.size();
        o_seq_idle <= (seq_phase == i2c_mbe_pkg::PH_IDLE);
    end

endmodule

// ----- tb/sv/i2c_master_byte_engine_tb.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives bus ticks with commands and sampled pin levels, with random gaps and
// result stalls, one long result hold-off and one gap-free stretch. Runs a
// gap-free stop at the reset tick count, short directed transfers at zero
// ticks, then random transfers at several small tick counts. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int IDLE_PCT      = 26;
    localparam int SCL_HIGH_PCT  = 85;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_TICKS  = 240;
    localparam int CMD_BITS      = i2c_mbe_pkg::CMD_W;
    localparam int HB_BITS       = i2c_mbe_pkg::HB_W;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic [CMD_BITS-1:0] command = i2c_mbe_pkg::CMD_NONE;
    logic [7:0]          tx_byte = '0;
    logic                nack_to_send = 1'b0;
    logic                scl_in = 1'b1;
    logic                sda_in = 1'b1;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [HB_BITS-1:0]  cfg_data = i2c_mbe_pkg::HALFBIT_RESET;

    wire                 in_stall;
    wire                 out_valid;
    wire                 scl_release;
    wire                 sda_release;
    wire                 busy_res;
    wire                 done_res;
    wire  [7:0]          rx_byte;
    wire                 ack_seen;
    wire                 cfg_ready;
    int                  fail_count;
    int                  pending;
    logic                seq_idle;

    logic                no_gaps = 1'b0;
    logic                pressure_go = 1'b0;
    logic                held_once = 1'b0;
    logic                last_was_cmd = 1'b0;
    int                  hang_ticks = 0;
    int                  cycles = 0;
    i2c_mbe_pkg::t_request cmd_plan[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    i2c_master_byte_engine dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_tx_byte      (tx_byte),
        .i_nack_to_send (nack_to_send),
        .i_scl_in       (scl_in),
        .i_sda_in       (sda_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_scl_release  (scl_release),
        .o_sda_release  (sda_release),
        .o_busy_res     (busy_res),
        .o_done_res     (done_res),
        .o_rx_byte      (rx_byte),
        .o_ack_seen     (ack_seen),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    i2c_master_byte_engine_checker bus_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_command      (command),
        .i_tx_byte      (tx_byte),
        .i_nack_to_send (nack_to_send),
        .i_scl_in       (scl_in),
        .i_sda_in       (sda_in),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_scl_release  (scl_release),
        .i_sda_release  (sda_release),
        .i_busy_res     (busy_res),
        .i_done_res     (done_res),
        .i_rx_byte      (rx_byte),
        .i_ack_seen     (ack_seen),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_seq_idle     (seq_idle)
    );

    task automatic offer_tick(input logic [CMD_BITS-1:0] cmd, input logic [7:0] tx,
                              input logic nack);
        logic stalled;
        logic scl_pick;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (hang_ticks > 0) begin
            hang_ticks--;
            scl_pick = 1'b0;
        end else begin
            scl_pick = ($urandom_range(0, 99) < SCL_HIGH_PCT);
        end
        in_valid <= 1'b1;
        command <= cmd;
        tx_byte <= tx;
        nack_to_send <= nack;
        scl_in <= scl_pick;
        sda_in <= 1'($urandom_range(0, 1));
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        last_was_cmd = (cmd != i2c_mbe_pkg::CMD_NONE);
    endtask

    task automatic idle_tick();
        offer_tick(i2c_mbe_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
    endtask

    // The idle flag lags one request, so a command goes out only after a
    // request without one.
    task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [7:0] tx,
                         input logic nack);
        while (!(seq_idle && !last_was_cmd)) begin
            idle_tick();
        end
        offer_tick(cmd, tx, nack);
    endtask

    task automatic drain();
        while (!(seq_idle && !last_was_cmd)) begin
            idle_tick();
        end
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_halfbit(input logic [HB_BITS-1:0] ticks);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_data <= ticks;
        do begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
    endtask

    task automatic plan_cmd(input logic [CMD_BITS-1:0] cmd);
        i2c_mbe_pkg::t_request rq;
        rq.command = cmd;
        rq.tx_byte = 8'($urandom);
        rq.nack_to_send = 1'($urandom);
        rq.scl_in = 1'b1;
        rq.sda_in = 1'b1;
        cmd_plan.push_back(rq);
    endtask

    task automatic plan_transfer();
        int n;
        n = $urandom_range(1, 3);
        plan_cmd(i2c_mbe_pkg::CMD_START);
        repeat (n) begin
            plan_cmd($urandom_range(0, 1) ? i2c_mbe_pkg::CMD_WRITE : i2c_mbe_pkg::CMD_READ);
            if ($urandom_range(0, 9) < 2) begin
                plan_cmd(i2c_mbe_pkg::CMD_START);
            end
        end
        plan_cmd(i2c_mbe_pkg::CMD_STOP);
    endtask

    task automatic random_ticks(input int n, input int pressure_at);
        i2c_mbe_pkg::t_request rq;
        for (int i = 0; i < n; i++) begin
            if (i == pressure_at) begin
                pressure_go <= 1'b1;
            end
            if (seq_idle && !last_was_cmd) begin
                if (cmd_plan.size() == 0) begin
                    if ($urandom_range(0, 99) < 80) begin
                        plan_transfer();
                    end else begin
                        plan_cmd(CMD_BITS'($urandom_range(0, 2**CMD_BITS - 1)));
                    end
                end
                rq = cmd_plan.pop_front();
                offer_tick(rq.command, rq.tx_byte, rq.nack_to_send);
            end else if ($urandom_range(0, 99) < 8) begin
                offer_tick(CMD_BITS'($urandom_range(0, 2**CMD_BITS - 1)), 8'($urandom),
                           1'($urandom));
            end else begin
                idle_tick();
            end
            if ($urandom_range(0, 99) == 0) begin
                hang_ticks = $urandom_range(2, 20);
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (pressure_go && !held_once) begin
                held_once = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= (!no_gaps && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        no_gaps <= 1'b1;
        issue(i2c_mbe_pkg::CMD_STOP, 8'h00, 1'b0);
        drain();
        no_gaps <= 1'b0;

        set_halfbit(16'd0);
        issue(i2c_mbe_pkg::CMD_START, 8'h00, 1'b0);
        issue(i2c_mbe_pkg::CMD_WRITE, 8'h00, 1'b0);
        issue(i2c_mbe_pkg::CMD_WRITE, 8'hFF, 1'b1);
        issue(i2c_mbe_pkg::CMD_READ, 8'hFF, 1'b0);
        issue(i2c_mbe_pkg::CMD_READ, 8'h00, 1'b1);
        issue(i2c_mbe_pkg::CMD_START, 8'h00, 1'b0);
        // The slave holds SCL low for a long time while the start before this byte runs.
        hang_ticks = 40;
        issue(i2c_mbe_pkg::CMD_WRITE, 8'h5A, 1'b0);
        for (int c = i2c_mbe_pkg::CMD_READ + 1; c < 2**CMD_BITS; c++) begin
            issue(CMD_BITS'(c), 8'hFF, 1'b1);
        end
        issue(i2c_mbe_pkg::CMD_STOP, 8'h00, 1'b0);
        // Commands on every tick while busy, the completion tick included.
        do begin
            offer_tick(i2c_mbe_pkg::CMD_WRITE, 8'($urandom), 1'($urandom));
        end while (!seq_idle);
        drain();

        set_halfbit(16'd1);
        random_ticks(RANDOM_TICKS, -1);
        drain();
        set_halfbit(16'd0);
        random_ticks(RANDOM_TICKS, RANDOM_TICKS / 3);
        drain();
        set_halfbit(16'd3);
        random_ticks(RANDOM_TICKS, -1);
        drain();
        set_halfbit(16'd2);
        random_ticks(RANDOM_TICKS, -1);
        drain();
        set_halfbit(HB_BITS'($urandom_range(0, 5)));
        random_ticks(RANDOM_TICKS, -1);
        drain();

        @(negedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
